// File: rtl/image_border_padder_top_defines.svh
// Assertion macros for the checker file of the border padder.
`ifndef IMAGE_BORDER_PADDER_TOP_DEFINES_SVH
`define IMAGE_BORDER_PADDER_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define IBP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked through reset.
`define IBP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ibp_pkg.sv
// Shared constants, codes and the queue entry type of the border padder.
`default_nettype none

package ibp_pkg;

  localparam int MAX_WIDTH       = 4096;
  localparam int MAX_HEIGHT      = 4096;
  localparam int PIXEL_BITS      = 32;
  localparam int CFG_BITS        = 13;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int COORD_BITS      = 12;
  localparam int COL_BITS        = $clog2(MAX_WIDTH);
  localparam int ROW_BITS        = $clog2(MAX_HEIGHT);
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic KIND_SOURCE = 1'b0;

  // How the back end forms the destination pixel of one entry.
  typedef enum logic [1:0] {
    OP_SOURCE,
    OP_ZERO,
    OP_LATEST,
    OP_FIRST
  } pix_op_t;

  typedef struct packed {
    pix_op_t                 op;
    logic [PIXEL_BITS-1:0]   pixel;
    logic [COL_BITS-1:0]     col;
    logic [ROW_BITS-1:0]     row;
    logic [COL_BITS-1:0]     addr;
    logic                    eor;
    logic                    eof;
    logic                    mismatch;
    logic                    wr_latest;
    logic                    wr_first;
  } task_t;

endpackage

`default_nettype wire

// File: rtl/ibp_stream_if.sv
// Valid/ready stream interfaces for the input items and the result items.
`default_nettype none

interface ibp_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [ibp_pkg::PIXEL_BITS-1:0]   pixel_in;

  modport source (output valid, kind, pixel_in, input ready);
  modport sink (input valid, kind, pixel_in, output ready);
endinterface

interface ibp_out_if;
  logic                             valid;
  logic                             ready;
  logic [ibp_pkg::PIXEL_BITS-1:0]   pixel_out;
  logic [ibp_pkg::COORD_BITS-1:0]   column;
  logic [ibp_pkg::COORD_BITS-1:0]   row;
  logic                             end_of_row;
  logic                             end_of_frame;
  logic                             kind_mismatch;

  modport source (
    output valid, pixel_out, column, row, end_of_row, end_of_frame, kind_mismatch,
    input ready
  );
  modport sink (
    input valid, pixel_out, column, row, end_of_row, end_of_frame, kind_mismatch,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/ibp_front.sv
// Front end: size registers, destination position and item classification.
`default_nettype none

module ibp_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ibp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ibp_pkg::CFG_BITS-1:0]        cfg_data,
  ibp_in_if.sink                              in_ch,
  output logic                                push_valid,
  input  logic                                push_ready,
  output ibp_pkg::task_t                      push_data
);

  localparam int SB = ibp_pkg::CFG_BITS;
  localparam int CB = ibp_pkg::COL_BITS;
  localparam int RB = ibp_pkg::ROW_BITS;
  localparam logic [SB-1:0] MAX_W = SB'(ibp_pkg::MAX_WIDTH);
  localparam logic [SB-1:0] MAX_H = SB'(ibp_pkg::MAX_HEIGHT);

  logic [SB-1:0] src_width;
  logic [SB-1:0] src_height;
  logic [SB-1:0] dst_width;
  logic [SB-1:0] dst_height;
  logic [CB-1:0] col_cnt;
  logic [RB-1:0] row_cnt;

  logic [SB-1:0] sw, sh, dw, dh;
  logic          col_wrap;
  logic [RB:0]   row_a;
  logic [CB-1:0] col_n, col_adv;
  logic [RB-1:0] row_n, row_adv;
  logic          in_src, last_col, last_row, mismatch, in_fire;
  ibp_pkg::task_t t;

  function automatic logic [SB-1:0] clamp_src(input logic [SB-1:0] v,
                                               input logic [SB-1:0] maxv);
    logic [SB-1:0] r;
    r = v;
    if (r == '0) r = SB'(1);
    if (r > maxv) r = maxv;
    return r;
  endfunction

  function automatic logic [SB-1:0] clamp_dst(input logic [SB-1:0] v,
                                               input logic [SB-1:0] srcv,
                                               input logic [SB-1:0] maxv);
    logic [SB-1:0] r;
    r = v;
    if (r > maxv) r = maxv;
    if (r < srcv) r = srcv;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SB'(1);
      src_height <= SB'(1);
      dst_width  <= SB'(1);
      dst_height <= SB'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ibp_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data;
        ibp_pkg::REG_SRC_HEIGHT: src_height <= cfg_data;
        ibp_pkg::REG_DST_WIDTH:  dst_width  <= cfg_data;
        ibp_pkg::REG_DST_HEIGHT: dst_height <= cfg_data;
      endcase
    end
  end

  assign sw = clamp_src(src_width, MAX_W);
  assign sh = clamp_src(src_height, MAX_H);
  assign dw = clamp_dst(dst_width, sw, MAX_W);
  assign dh = clamp_dst(dst_height, sh, MAX_H);

  // Pull the position back inside the frame if the sizes shrank under it.
  always_comb begin
    col_wrap = SB'(col_cnt) >= dw;
    row_a    = col_wrap ? ((RB+1)'(row_cnt) + 1'b1) : (RB+1)'(row_cnt);
    col_n    = col_wrap ? '0 : col_cnt;
    row_n    = (SB'(row_a) >= dh) ? '0 : row_a[RB-1:0];
    in_src   = (SB'(row_n) < sh) && (SB'(col_n) < sw);
    last_col = SB'(col_n) == (dw - SB'(1));
    last_row = SB'(row_n) == (dh - SB'(1));
    mismatch = (in_ch.kind == ibp_pkg::KIND_SOURCE) != in_src;
    if (last_col) begin
      col_adv = '0;
      row_adv = last_row ? '0 : row_n + 1'b1;
    end else begin
      col_adv = col_n + 1'b1;
      row_adv = row_n;
    end
  end

  always_comb begin
    t.op        = ibp_pkg::OP_ZERO;
    t.pixel     = in_ch.pixel_in;
    t.col       = col_n;
    t.row       = row_n;
    t.addr      = col_n;
    t.eor       = 1'b0;
    t.eof       = 1'b0;
    t.mismatch  = mismatch;
    t.wr_latest = 1'b0;
    t.wr_first  = 1'b0;
    if (!mismatch) begin
      t.eor = last_col;
      t.eof = last_col && last_row;
      if (SB'(row_n) < sh) begin
        // Source rows are recorded so that the padding rows can repeat them.
        t.wr_latest = 1'b1;
        t.wr_first  = row_n == '0;
        if (SB'(col_n) < sw) begin
          t.op = ibp_pkg::OP_SOURCE;
        end else if (SB'(col_n) == sw) begin
          t.op   = ibp_pkg::OP_LATEST;
          t.addr = CB'(sw - SB'(1));
        end else if (last_col) begin
          t.op   = ibp_pkg::OP_LATEST;
          t.addr = '0;
        end
      end else if (SB'(row_n) == sh) begin
        t.op = ibp_pkg::OP_LATEST;
      end else if (last_row) begin
        t.op = ibp_pkg::OP_FIRST;
      end
    end
  end

  assign push_data   = t;
  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;
  assign in_fire     = in_ch.valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_fire) begin
      if (mismatch) begin
        col_cnt <= col_n;
        row_cnt <= row_n;
      end else begin
        col_cnt <= col_adv;
        row_cnt <= row_adv;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ibp_queue.sv
// Small register queue that decouples the front end from the back end.
`default_nettype none

module ibp_queue #(
  parameter int DEPTH = ibp_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  ibp_pkg::task_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ibp_pkg::task_t pop_data
);

  localparam int PB = $clog2(DEPTH);
  localparam int NB = $clog2(DEPTH + 1);

  ibp_pkg::task_t slots [DEPTH];
  logic [PB-1:0]  wr_ptr;
  logic [PB-1:0]  rd_ptr;
  logic [NB-1:0]  count;
  logic           push, pop;

  assign push_ready = count != NB'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PB'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PB'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/ibp_back.sv
// Back end: row store reads and writes, pixel selection and output register.
`default_nettype none

module ibp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  ibp_pkg::task_t pop_data,
  ibp_out_if.source      out_ch
);

  localparam int PW = ibp_pkg::PIXEL_BITS;
  localparam int KW = ibp_pkg::COORD_BITS;

  logic [PW-1:0] latest_mem [ibp_pkg::MAX_WIDTH];
  logic [PW-1:0] first_mem [ibp_pkg::MAX_WIDTH];

  ibp_pkg::task_t s1;
  logic           s1_valid;
  logic [PW-1:0]  latest_rd, first_rd, byp_pix;
  logic           byp_latest, byp_first;
  logic [PW-1:0]  pix;
  logic           out_load, s1_ready, pop, wr_latest_now, wr_first_now;

  logic           out_valid;
  logic [PW-1:0]  out_pixel;
  logic [KW-1:0]  out_column, out_row;
  logic           out_eor, out_eof, out_mismatch;

  assign out_load      = s1_valid && (!out_valid || out_ch.ready);
  assign s1_ready      = !s1_valid || out_load;
  assign pop_ready     = s1_ready;
  assign pop           = pop_valid && s1_ready;
  assign wr_latest_now = out_load && s1.wr_latest;
  assign wr_first_now  = out_load && s1.wr_first;

  always_comb begin
    case (s1.op)
      ibp_pkg::OP_SOURCE: pix = s1.pixel;
      ibp_pkg::OP_LATEST: pix = byp_latest ? byp_pix : latest_rd;
      ibp_pkg::OP_FIRST:  pix = byp_first ? byp_pix : first_rd;
      default:            pix = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_latest_now) begin
      latest_mem[s1.col] <= pix;
    end
    if (pop) begin
      latest_rd <= latest_mem[pop_data.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_first_now) begin
      first_mem[s1.col] <= pix;
    end
    if (pop) begin
      first_rd <= first_mem[pop_data.addr];
    end
  end

  // A read that meets the write of the entry ahead takes the written pixel.
  always_ff @(posedge clk) begin
    if (pop) begin
      s1         <= pop_data;
      byp_latest <= wr_latest_now && (s1.col == pop_data.addr);
      byp_first  <= wr_first_now && (s1.col == pop_data.addr);
      byp_pix    <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pop_valid;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel    <= pix;
      out_column   <= KW'(s1.col);
      out_row      <= KW'(s1.row);
      out_eor      <= s1.eor;
      out_eof      <= s1.eof;
      out_mismatch <= s1.mismatch;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.pixel_out     = out_pixel;
  assign out_ch.column        = out_column;
  assign out_ch.row           = out_row;
  assign out_ch.end_of_row    = out_eor;
  assign out_ch.end_of_frame  = out_eof;
  assign out_ch.kind_mismatch = out_mismatch;

endmodule

`default_nettype wire

// File: rtl/image_border_padder_top.sv
// Path: an item is held in the queue, then in the back end stage and the output register.
// Throughput: one item per cycle; the input stays ready while the two-entry queue has room.
// The row store memories take one read and one write per cycle, which sets that rate.
// Reset is synchronous: it sets all four size registers to one, the position to the
// first pixel, and empties the queue and the pipeline. The row stores are not cleared.
`default_nettype none

// The padder takes one input item per destination pixel in raster order. Source
// positions take source pixels; every padding position takes a fill tick. Each item
// yields exactly one result transfer. An item of the wrong kind for its position is
// answered with kind_mismatch set and does not move the position.
//
// The front end holds the size registers and the destination position. It clamps
// the sizes, decides whether the item matches its position and works out how the
// pixel is formed: passed through, zero, or read back from one of two row stores.
// While the output side is stalled, the queue takes items until it is full.
// The back end reads the row stores, picks the pixel, records source rows and
// presents the result in an output register.
module image_border_padder_top #(
  parameter int QUEUE_DEPTH = ibp_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ibp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ibp_pkg::CFG_BITS-1:0]        cfg_data,
  ibp_in_if.sink                              in_ch,
  ibp_out_if.source                           out_ch
);

  // Front end to queue.
  logic           push_valid;
  logic           push_ready;
  ibp_pkg::task_t push_data;

  // Queue to back end.
  logic           pop_valid;
  logic           pop_ready;
  ibp_pkg::task_t pop_data;

  ibp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // The queue depth sets how many classified items may wait for the back end.
  ibp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back end forwards a row store write to a read of the same entry in the
  // same cycle, so padding columns see the pixel written just before them.
  ibp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: rtl/ibp_checker.sv
// Port-level checks on the result stream of the border padder, bound to the top.
`default_nettype none

`include "image_border_padder_top_defines.svh"

module ibp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ibp_pkg::PIXEL_BITS-1:0]   pixel_out,
  input logic [ibp_pkg::COORD_BITS-1:0]   column,
  input logic [ibp_pkg::COORD_BITS-1:0]   row,
  input logic                             end_of_row,
  input logic                             end_of_frame,
  input logic                             kind_mismatch
);

  // A stalled result keeps its valid and its whole payload.
  `IBP_ASSERT_NXT(a_out_hold, !rst && out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(column) && $stable(row) && $stable(end_of_row) && $stable(end_of_frame) && $stable(kind_mismatch), "stalled result changed")

  // A rejected item carries a black pixel and no row or frame end.
  `IBP_ASSERT_IMP(a_mismatch_clean, out_valid && kind_mismatch, pixel_out == '0 && !end_of_row && !end_of_frame, "mismatch result not clean")

  // The last pixel of the frame is also the last pixel of its row.
  `IBP_ASSERT_IMP(a_eof_eor, out_valid && end_of_frame, end_of_row, "frame end without row end")

  // Reset empties the output register.
  `IBP_ASSERT_NXT(a_reset_empty, rst, !out_valid, "result valid after reset")

endmodule

bind image_border_padder_top ibp_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .pixel_out     (out_ch.pixel_out),
  .column        (out_ch.column),
  .row           (out_ch.row),
  .end_of_row    (out_ch.end_of_row),
  .end_of_frame  (out_ch.end_of_frame),
  .kind_mismatch (out_ch.kind_mismatch)
);

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the image border padder: stimulus, prediction and checks.
`timescale 1ns / 100ps

module tb;

  // A fill tick is the opposite of a source pixel on the one-bit kind field.
  localparam logic KIND_FILL = ~ibp_pkg::KIND_SOURCE;

  // Cycles from an input transfer until its result is valid with a free output.
  localparam int LATENCY = 2;

  // A correct run never goes this long without a transfer on either channel. The worst
  // stall is a run of random idle cycles plus the configuration writes between phases.
  localparam int QUIET_LIMIT = 2000;

  // Random items after the directed and extreme phases.
  localparam int RANDOM_ITEMS = 1500;

  typedef logic [ibp_pkg::CFG_BITS-1:0] size_t;

  // One destination pixel as the block presents it on the output channel.
  typedef struct packed {
    logic [ibp_pkg::PIXEL_BITS-1:0] pixel_out;
    logic [ibp_pkg::COORD_BITS-1:0] column;
    logic [ibp_pkg::COORD_BITS-1:0] row;
    logic                           end_of_row;
    logic                           end_of_frame;
    logic                           kind_mismatch;
  } dest_pixel_t;

  // The scoreboard keeps its own copy of the size registers, the destination
  // position and both row stores. Every accepted input item is turned into the
  // destination pixel it must produce, and results are matched in order.
  class padder_scoreboard;
    logic [ibp_pkg::CFG_BITS-1:0]   src_w, src_h, dst_w, dst_h;
    int unsigned                    col_pos, row_pos;
    logic [ibp_pkg::PIXEL_BITS-1:0] first_row [ibp_pkg::MAX_WIDTH];
    logic [ibp_pkg::PIXEL_BITS-1:0] latest_row [ibp_pkg::MAX_WIDTH];
    dest_pixel_t                    pending_pixels [$];
    int unsigned                    error_count;

    function new();
      src_w = 1;
      src_h = 1;
      dst_w = 1;
      dst_h = 1;
      col_pos = 0;
      row_pos = 0;
      error_count = 0;
      foreach (first_row[i]) begin
        first_row[i] = '0;
        latest_row[i] = '0;
      end
    endfunction

    function void write_reg(logic [ibp_pkg::CFG_INDEX_BITS-1:0] index,
                            logic [ibp_pkg::CFG_BITS-1:0] value);
      case (index)
        ibp_pkg::REG_SRC_WIDTH:  src_w = value;
        ibp_pkg::REG_SRC_HEIGHT: src_h = value;
        ibp_pkg::REG_DST_WIDTH:  dst_w = value;
        ibp_pkg::REG_DST_HEIGHT: dst_h = value;
        default: ;
      endcase
    endfunction

    // Effective sizes and the position the next item lands on. A position left
    // outside the frame by a size change moves to the next row, or back to row 0.
    function void locate(output int unsigned col, row, sw, sh, dw, dh);
      sw = (src_w == 0) ? 1 :
           ((src_w > ibp_pkg::MAX_WIDTH) ? ibp_pkg::MAX_WIDTH : src_w);
      sh = (src_h == 0) ? 1 :
           ((src_h > ibp_pkg::MAX_HEIGHT) ? ibp_pkg::MAX_HEIGHT : src_h);
      dw = (dst_w > ibp_pkg::MAX_WIDTH) ? ibp_pkg::MAX_WIDTH : dst_w;
      dh = (dst_h > ibp_pkg::MAX_HEIGHT) ? ibp_pkg::MAX_HEIGHT : dst_h;
      if (dw < sw) dw = sw;
      if (dh < sh) dh = sh;
      col = col_pos;
      row = row_pos;
      if (col >= dw) begin
        col = 0;
        row++;
      end
      if (row >= dh) row = 0;
    endfunction

    function bit next_is_source();
      int unsigned col, row, sw, sh, dw, dh;
      locate(col, row, sw, sh, dw, dh);
      return (row < sh) && (col < sw);
    endfunction

    function bit at_frame_start();
      int unsigned col, row, sw, sh, dw, dh;
      locate(col, row, sw, sh, dw, dh);
      return (col == 0) && (row == 0);
    endfunction

    function int unsigned frame_pixels();
      int unsigned col, row, sw, sh, dw, dh;
      locate(col, row, sw, sh, dw, dh);
      return dw * dh;
    endfunction

    function void note_input(logic kind, logic [ibp_pkg::PIXEL_BITS-1:0] pix);
      int unsigned                    col, row, sw, sh, dw, dh;
      bit                             in_source;
      logic [ibp_pkg::PIXEL_BITS-1:0] px;
      dest_pixel_t                    want;
      locate(col, row, sw, sh, dw, dh);
      col_pos = col;
      row_pos = row;
      in_source = (row < sh) && (col < sw);
      want = '0;
      want.column = col[ibp_pkg::COORD_BITS-1:0];
      want.row = row[ibp_pkg::COORD_BITS-1:0];
      // The wrong kind is flagged in place and leaves the position and the stores alone.
      if ((kind == ibp_pkg::KIND_SOURCE) != in_source) begin
        want.kind_mismatch = 1'b1;
        pending_pixels.push_back(want);
        return;
      end
      if (row < sh) begin
        if (col < sw) px = pix;
        else if (col == sw) px = latest_row[sw - 1];
        else if (col == dw - 1) px = latest_row[0];
        else px = '0;
        latest_row[col] = px;
        if (row == 0) first_row[col] = px;
      end else if (row == sh) begin
        px = latest_row[col];
      end else if (row == dh - 1) begin
        px = first_row[col];
      end else begin
        px = '0;
      end
      want.pixel_out = px;
      want.end_of_row = (col == dw - 1);
      want.end_of_frame = want.end_of_row && (row == dh - 1);
      pending_pixels.push_back(want);
      col_pos = col + 1;
      if (col_pos >= dw) begin
        col_pos = 0;
        row_pos = row + 1;
        if (row_pos >= dh) row_pos = 0;
      end
    endfunction

    task report(string msg);
      if (error_count < 200) $display("mismatch: %s", msg);
      error_count++;
    endtask

    task check_result(dest_pixel_t got);
      dest_pixel_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected result at column %0d row %0d", got.column, got.row));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_out != want.pixel_out)
        report($sformatf("pixel_out %h, want %h (column %0d row %0d)",
                         got.pixel_out, want.pixel_out, want.column, want.row));
      if (got.column != want.column)
        report($sformatf("column %0d, want %0d", got.column, want.column));
      if (got.row != want.row)
        report($sformatf("row %0d, want %0d", got.row, want.row));
      if (got.end_of_row != want.end_of_row)
        report($sformatf("end_of_row %b, want %b (column %0d row %0d)",
                         got.end_of_row, want.end_of_row, want.column, want.row));
      if (got.end_of_frame != want.end_of_frame)
        report($sformatf("end_of_frame %b, want %b (column %0d row %0d)",
                         got.end_of_frame, want.end_of_frame, want.column, want.row));
      if (got.kind_mismatch != want.kind_mismatch)
        report($sformatf("kind_mismatch %b, want %b (column %0d row %0d)",
                         got.kind_mismatch, want.kind_mismatch, want.column, want.row));
    endtask
  endclass

  logic                               clk;
  logic                               rst;
  logic                               cfg_we;
  logic [ibp_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [ibp_pkg::CFG_BITS-1:0]       cfg_data;

  ibp_in_if  in_ch ();
  ibp_out_if out_ch ();

  image_border_padder_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  padder_scoreboard board;

  // While steady is set neither side inserts idle cycles.
  bit          steady = 1'b0;
  int unsigned items_sent = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Inputs take known values at time zero, before the first clock edge.
  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= ibp_pkg::KIND_SOURCE;
    in_ch.pixel_in <= '0;
    out_ch.ready <= 1'b0;
  end

  function automatic logic [ibp_pkg::PIXEL_BITS-1:0] pick_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Presents one item and holds it until the block takes it. The scoreboard notes
  // the item at the edge of the transfer. Afterwards the sender may idle, and now
  // and then it stops until every expected result has come back.
  // All signal changes happen with nonblocking assignments at clock edges, and
  // valid is never lowered and raised within one time step.
  task automatic send_item(logic kind, logic [ibp_pkg::PIXEL_BITS-1:0] pix);
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.pixel_in <= pix;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(kind, pix);
    items_sent++;
    while (!steady && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    if (!steady && $urandom_range(199) == 0) drain();
  endtask

  // Drops valid and waits until no result is outstanding. It returns only once the
  // lowered valid has been sampled, so the caller may raise valid again at once.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending_pixels.size() != 0);
  endtask

  // One register write per edge; the caller lowers the write enable afterwards.
  task automatic write_reg(logic [ibp_pkg::CFG_INDEX_BITS-1:0] index,
                           logic [ibp_pkg::CFG_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    board.write_reg(index, value);
    @(posedge clk);
  endtask

  // Called only when the block is idle: right after reset or after a drain.
  task automatic set_sizes(size_t sw, size_t sh, size_t dw, size_t dh);
    write_reg(ibp_pkg::REG_SRC_WIDTH, sw);
    write_reg(ibp_pkg::REG_SRC_HEIGHT, sh);
    write_reg(ibp_pkg::REG_DST_WIDTH, dw);
    write_reg(ibp_pkg::REG_DST_HEIGHT, dh);
    cfg_we <= 1'b0;
  endtask

  // Feeds the item each position calls for, with random content. A few positions
  // first get an item of the wrong kind, which must be flagged and not advance.
  task automatic feed_positions(int unsigned count);
    repeat (count) begin
      bit src;
      src = board.next_is_source();
      if ($urandom_range(99) < 4)
        send_item(src ? KIND_FILL : ibp_pkg::KIND_SOURCE, pick_pixel());
      send_item(src ? ibp_pkg::KIND_SOURCE : KIND_FILL, pick_pixel());
    end
  endtask

  // Sizes change only at frame starts, except in the deliberate mid-frame cases,
  // so that no row store entry is ever read before the frame has written it.
  task automatic finish_frame();
    while (!board.at_frame_start()) feed_positions(1);
  endtask

  // Mostly small frames; a few wide ones; sometimes a padded size below the
  // source size, which the block must raise to the source size.
  task automatic random_phase();
    int unsigned sw, sh, dw, dh, total, cut;
    if ($urandom_range(9) == 0) begin
      sw = $urandom_range(40, 8);
      sh = $urandom_range(3, 1);
    end else begin
      sw = $urandom_range(6, 1);
      sh = $urandom_range(5, 1);
    end
    dw = ($urandom_range(99) < 15) ? $urandom_range(sw) : sw + $urandom_range(6);
    dh = ($urandom_range(99) < 15) ? $urandom_range(sh) : sh + $urandom_range(4);
    set_sizes(size_t'(sw), size_t'(sh), size_t'(dw), size_t'(dh));
    total = board.frame_pixels() * $urandom_range(3, 1);
    cut = $urandom_range(total);
    feed_positions(cut);
    // Now and then a burst of items of random kind breaks into the frame.
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(12, 3)) send_item(1'($urandom_range(1)), pick_pixel());
    feed_positions(total - cut);
    finish_frame();
  endtask

  // The receiver takes a result at each edge where valid and ready were both
  // high, then picks its ready for the next cycle. It stays low during reset.
  initial begin
    dest_pixel_t got;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.pixel_out = out_ch.pixel_out;
        got.column = out_ch.column;
        got.row = out_ch.row;
        got.end_of_row = out_ch.end_of_row;
        got.end_of_frame = out_ch.end_of_frame;
        got.kind_mismatch = out_ch.kind_mismatch;
        board.check_result(got);
      end
      out_ch.ready <= !rst && (steady || $urandom_range(99) >= 28);
    end
  end

  // The watchdog ends a run in which nothing moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("no transfer for %0d cycles", QUIET_LIMIT);
    $display("image_border_padder_top regression: fail");
    $finish;
  end

  initial begin
    int unsigned random_start;
    bit          src;
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset every size is one, so each frame is a single source pixel.
    // A fill tick there is the wrong kind.
    send_item(ibp_pkg::KIND_SOURCE, '0);
    send_item(KIND_FILL, '1);
    send_item(ibp_pkg::KIND_SOURCE, '1);

    // A 2x2 source in a 5x4 frame shows these padding rules: the column after the
    // source repeats the last pixel, the last column repeats the first, the column
    // between is black; the row after the source repeats the last padded row, the
    // last row repeats the first one. Two positions first get the wrong kind.
    drain();
    set_sizes(2, 2, 5, 4);
    for (int i = 0; i < 20; i++) begin
      src = board.next_is_source();
      if (i == 2 || i == 6) send_item(src ? KIND_FILL : ibp_pkg::KIND_SOURCE, pick_pixel());
      send_item(src ? ibp_pkg::KIND_SOURCE : KIND_FILL, pick_pixel());
    end

    // Zero source sizes count as one.
    drain();
    set_sizes(0, 0, 3, 2);
    feed_positions(board.frame_pixels());

    // Width shrinks mid-frame while the position sits in the padding of row 1,
    // which moves the position to the start of row 2.
    drain();
    set_sizes(4, 3, 8, 6);
    feed_positions(14);
    drain();
    set_sizes(4, 3, 5, 6);
    finish_frame();

    // Height shrinks mid-frame below the current row, which sends it back to row 0.
    drain();
    set_sizes(3, 2, 4, 7);
    feed_positions(20);
    drain();
    set_sizes(3, 2, 4, 4);
    finish_frame();
    feed_positions(board.frame_pixels());

    // Register values above the maximum saturate: the start of one full-width row,
    // then the first rows of a full-height frame two columns wide. A padded size of
    // zero is raised. Both frames are left mid-way, and the next size change moves
    // the position: to the start of row 1, then back to row 0.
    drain();
    set_sizes(8191, 0, 8191, 0);
    feed_positions(48);
    drain();
    set_sizes(0, 8191, 2, 8191);
    feed_positions(96);

    // Random sizes and content, with one long stretch in which nobody idles.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      drain();
      steady = (items_sent - random_start >= 400) && (items_sent - random_start < 750);
      random_phase();
    end
    steady = 1'b0;

    drain();
    repeat (LATENCY + 5) @(posedge clk);
    if (board.pending_pixels.size() != 0)
      board.report($sformatf("%0d results never arrived", board.pending_pixels.size()));
    if (board.error_count == 0) begin
      $display("image_border_padder_top regression: pass");
    end else begin
      $display("image_border_padder_top regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ibp_pkg.sv
rtl/ibp_stream_if.sv
rtl/ibp_front.sv
rtl/ibp_queue.sv
rtl/ibp_back.sv
rtl/image_border_padder_top.sv
rtl/ibp_checker.sv
test/tb.sv
